### hdl/pcg_pkg.sv
// Shared types, constants and functions of the PCG64 bounded random generator.
`default_nettype none
package pcg_pkg;

  typedef enum logic [2:0] {
    OP_RESEED   = 3'd0,
    OP_NEXT64   = 3'd1,
    OP_NEXT32   = 3'd2,
    OP_BOUNDED  = 3'd3,
    OP_FRACTION = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    REG_SEED_STATE_HIGH  = 2'd0,
    REG_SEED_STATE_LOW   = 2'd1,
    REG_SEED_STREAM_HIGH = 2'd2,
    REG_SEED_STREAM_LOW  = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_ADV, ST_POST, ST_LMUL, ST_LCHK, ST_DIV, ST_DONE
  } fsm_t;

  typedef enum logic [2:0] {
    PH_RS1, PH_RS2, PH_D64, PH_D32, PH_LEM
  } phase_t;

  localparam logic [127:0] LCG_MULT = {64'd2549297995355413924, 64'd4865540595714422341};
  localparam logic [63:0]  MASK32   = 64'h0000_0000_ffff_ffff;
  localparam int unsigned  ROT_SHIFT = 58;
  localparam int unsigned  NUM_PARTIALS = 10;

  // Word indices of the partial products s[i]*m[j] with i+j < 4.
  function automatic logic [1:0] part_i(input logic [3:0] k);
    case (k)
      4'd0, 4'd1, 4'd3, 4'd6: part_i = 2'd0;
      4'd2, 4'd4, 4'd7:       part_i = 2'd1;
      4'd5, 4'd8:             part_i = 2'd2;
      default:                part_i = 2'd3;
    endcase
  endfunction

  function automatic logic [1:0] part_j(input logic [3:0] k);
    case (k)
      4'd0, 4'd2, 4'd5, 4'd9: part_j = 2'd0;
      4'd1, 4'd4, 4'd8:       part_j = 2'd1;
      4'd3, 4'd7:             part_j = 2'd2;
      default:                part_j = 2'd3;
    endcase
  endfunction

  // XSL-RR output permutation of a 128-bit state.
  function automatic logic [63:0] xsl_rr(input logic [127:0] s);
    logic [63:0]  x;
    logic [5:0]   rot;
    logic [127:0] dbl;
    x   = s[127:64] ^ s[63:0];
    rot = s[127:64+ROT_SHIFT];
    dbl = {x, x} >> rot;
    xsl_rr = dbl[63:0];
  endfunction

endpackage
`default_nettype wire

### hdl/pcg64_bounded_random_generator_unit.sv
// Top level of the PCG64 generator with bounded, 32-bit, 64-bit and fraction draws.
`default_nettype none
// The unit takes one item at a time and returns exactly one result item for each. A draw
// advances the 128-bit state through a single shared 32x32 multiplier that works through
// the ten partial products of the state times the multiplier, one a cycle, into a 128-bit
// accumulator. A next32 served from the buffered half, a bounded item of range zero and
// an undefined operation skip the advance. Bounded draws wider than 32 bits, but for the
// full 64-bit range, go on to the bit-serial remainder unit; Lemire draws add a multiply
// and check per attempt on top of any draw, and use the remainder unit once when the
// rejection threshold must be worked out. Reseed runs two advances. item_ready is high
// only while the unit is idle; a finished result waits in the output register, and the
// next item may be accepted before it is taken. The seed registers are written over the
// APB port at byte addresses 0, 8, 16 and 24 and take effect at the next reseed item;
// software should reseed before the first draw.
module pcg64_bounded_random_generator_unit
  import pcg_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready,
  input  wire logic        item_valid,
  output logic             item_ready,
  input  wire logic [2:0]  operation,
  input  wire logic [63:0] offset,
  input  wire logic [63:0] range,
  output logic             result_valid,
  input  wire logic        result_ready,
  output logic [63:0]      value
);

  logic [63:0] seed_state_high, seed_state_low, seed_stream_high, seed_stream_low;

  fsm_t         fsm, fsm_next;
  phase_t       phase, phase_next;
  logic [2:0]   op_r, op_r_next;
  logic [63:0]  off_r, off_r_next;
  logic [63:0]  rng_r, rng_r_next;
  logic [127:0] lcg, lcg_next;
  logic [127:0] inc, inc_next;
  logic [31:0]  spare, spare_next;
  logic         spare_valid, spare_valid_next;
  logic [127:0] acc, acc_next;
  logic [3:0]   k, k_next;
  logic [63:0]  prod, prod_next;
  logic [1:0]   prod_sh, prod_sh_next;
  logic [31:0]  w, w_next;
  logic [31:0]  thresh, thresh_next;
  logic         have_thresh, have_thresh_next;
  logic [63:0]  res, res_next;
  logic         result_valid_next;
  logic [63:0]  value_next;

  logic [31:0]  mul_a, mul_b;
  logic [31:0]  excl;
  logic [63:0]  draw;
  logic [127:0] prod_wide;
  logic         div_start, div_busy, div_done;
  logic [63:0]  div_a, div_b, div_rem;
  logic         is_lem;

  // The configuration port answers at once.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed_state_high  <= '0;
      seed_state_low   <= '0;
      seed_stream_high <= '0;
      seed_stream_low  <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx_t'(paddr[4:3]))
        REG_SEED_STATE_HIGH:  seed_state_high  <= pwdata;
        REG_SEED_STATE_LOW:   seed_state_low   <= pwdata;
        REG_SEED_STREAM_HIGH: seed_stream_high <= pwdata;
        REG_SEED_STREAM_LOW:  seed_stream_low  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_t'(paddr[4:3]))
      REG_SEED_STATE_HIGH:  prdata = seed_state_high;
      REG_SEED_STATE_LOW:   prdata = seed_state_low;
      REG_SEED_STREAM_HIGH: prdata = seed_stream_high;
      REG_SEED_STREAM_LOW:  prdata = seed_stream_low;
      default:              prdata = '0;
    endcase
  end

  assign item_ready = (fsm == ST_IDLE);
  assign excl       = rng_r[31:0] + 32'd1;
  assign draw       = xsl_rr(lcg);
  assign is_lem     = (rng_r < MASK32);

  // The one multiplier serves both the state advance and the Lemire product.
  always_comb begin
    if (fsm == ST_LMUL) begin
      mul_a = w;
      mul_b = excl;
    end else begin
      mul_a = lcg[32*part_i(k) +: 32];
      mul_b = LCG_MULT[32*part_j(k) +: 32];
    end
  end

  // Place the registered partial product at its word offset.
  always_comb begin
    case (prod_sh)
      2'd0:    prod_wide = {64'd0, prod};
      2'd1:    prod_wide = {32'd0, prod, 32'd0};
      2'd2:    prod_wide = {prod, 64'd0};
      default: prod_wide = {prod[31:0], 96'd0};
    endcase
  end

  pcg_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .busy     (div_busy),
    .done     (div_done),
    .rem      (div_rem)
  );

  always_comb begin
    fsm_next          = fsm;
    phase_next        = phase;
    op_r_next         = op_r;
    off_r_next        = off_r;
    rng_r_next        = rng_r;
    lcg_next          = lcg;
    inc_next          = inc;
    spare_next        = spare;
    spare_valid_next  = spare_valid;
    acc_next          = acc;
    k_next            = k;
    prod_next         = prod;
    prod_sh_next      = prod_sh;
    w_next            = w;
    thresh_next       = thresh;
    have_thresh_next  = have_thresh;
    res_next          = res;
    result_valid_next = result_valid && !result_ready;
    value_next        = value;
    div_start         = 1'b0;
    div_a             = draw;
    div_b             = rng_r + 64'd1;

    unique case (fsm)
      ST_IDLE: begin
        if (item_valid) begin
          op_r_next        = operation;
          off_r_next       = offset;
          rng_r_next       = range;
          have_thresh_next = 1'b0;
          acc_next         = '0;
          k_next           = '0;
          fsm_next         = ST_ADV;
          case (operation)
            OP_RESEED: begin
              inc_next   = {seed_stream_high[62:0], seed_stream_low, 1'b1};
              lcg_next   = '0;
              phase_next = PH_RS1;
            end
            OP_NEXT64, OP_FRACTION: phase_next = PH_D64;
            OP_NEXT32: begin
              if (spare_valid) begin
                res_next         = {32'd0, spare};
                spare_valid_next = 1'b0;
                fsm_next         = ST_DONE;
              end else begin
                phase_next = PH_D32;
              end
            end
            OP_BOUNDED: begin
              if (range == 64'd0) begin
                res_next = offset;
                fsm_next = ST_DONE;
              end else if (range < MASK32) begin
                if (spare_valid) begin
                  w_next           = spare;
                  spare_valid_next = 1'b0;
                  fsm_next         = ST_LMUL;
                end else begin
                  phase_next = PH_LEM;
                end
              end else if (range == MASK32) begin
                if (spare_valid) begin
                  res_next         = offset + {32'd0, spare};
                  spare_valid_next = 1'b0;
                  fsm_next         = ST_DONE;
                end else begin
                  phase_next = PH_D32;
                end
              end else begin
                phase_next = PH_D64;
              end
            end
            default: begin
              res_next = '0;
              fsm_next = ST_DONE;
            end
          endcase
        end
      end

      ST_ADV: begin
        if (k < 4'(NUM_PARTIALS)) begin
          prod_next    = mul_a * mul_b;
          prod_sh_next = 2'(part_i(k) + part_j(k));
        end
        if (k != 4'd0 && k <= 4'(NUM_PARTIALS)) begin
          acc_next = acc + prod_wide;
        end
        k_next = k + 4'd1;
        if (k == 4'(NUM_PARTIALS + 1)) begin
          lcg_next = acc + inc;
          fsm_next = ST_POST;
        end
      end

      ST_POST: begin
        acc_next = '0;
        k_next   = '0;
        case (phase)
          PH_RS1: begin
            lcg_next   = lcg + {seed_state_high, seed_state_low};
            phase_next = PH_RS2;
            fsm_next   = ST_ADV;
          end
          PH_RS2: begin
            spare_valid_next = 1'b0;
            spare_next       = '0;
            res_next         = '0;
            fsm_next         = ST_DONE;
          end
          PH_D64: begin
            spare_valid_next = 1'b0;
            fsm_next         = ST_DONE;
            if (op_r == OP_FRACTION) begin
              res_next = draw >> 11;
            end else if (op_r == OP_BOUNDED) begin
              if (rng_r == '1) begin
                res_next = off_r + draw;
              end else begin
                div_start = 1'b1;
                fsm_next  = ST_DIV;
              end
            end else begin
              res_next = draw;
            end
          end
          PH_D32: begin
            spare_next       = draw[63:32];
            spare_valid_next = 1'b1;
            if (op_r == OP_BOUNDED) begin
              res_next = off_r + {32'd0, draw[31:0]};
            end else begin
              res_next = {32'd0, draw[31:0]};
            end
            fsm_next = ST_DONE;
          end
          default: begin
            spare_next       = draw[63:32];
            spare_valid_next = 1'b1;
            w_next           = draw[31:0];
            fsm_next         = ST_LMUL;
          end
        endcase
      end

      ST_LMUL: begin
        prod_next = mul_a * mul_b;
        fsm_next  = ST_LCHK;
      end

      ST_LCHK: begin
        if (have_thresh) begin
          if (prod[31:0] < thresh) begin
            if (spare_valid) begin
              w_next           = spare;
              spare_valid_next = 1'b0;
              fsm_next         = ST_LMUL;
            end else begin
              phase_next = PH_LEM;
              acc_next   = '0;
              k_next     = '0;
              fsm_next   = ST_ADV;
            end
          end else begin
            res_next = off_r + {32'd0, prod[63:32]};
            fsm_next = ST_DONE;
          end
        end else if (prod[31:0] < excl) begin
          div_a     = {32'd0, 32'hffff_ffff - rng_r[31:0]};
          div_b     = {32'd0, excl};
          div_start = 1'b1;
          fsm_next  = ST_DIV;
        end else begin
          res_next = off_r + {32'd0, prod[63:32]};
          fsm_next = ST_DONE;
        end
      end

      ST_DIV: begin
        if (div_done) begin
          if (is_lem) begin
            thresh_next      = div_rem[31:0];
            have_thresh_next = 1'b1;
            fsm_next         = ST_LCHK;
          end else begin
            res_next = off_r + div_rem;
            fsm_next = ST_DONE;
          end
        end
      end

      ST_DONE: begin
        if (!result_valid || result_ready) begin
          result_valid_next = 1'b1;
          value_next        = res;
          fsm_next          = ST_IDLE;
        end
      end

      default: fsm_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fsm          <= ST_IDLE;
      result_valid <= 1'b0;
      lcg          <= '0;
      inc          <= 128'd1;
      spare        <= '0;
      spare_valid  <= 1'b0;
      have_thresh  <= 1'b0;
      k            <= '0;
    end else begin
      fsm          <= fsm_next;
      result_valid <= result_valid_next;
      lcg          <= lcg_next;
      inc          <= inc_next;
      spare        <= spare_next;
      spare_valid  <= spare_valid_next;
      have_thresh  <= have_thresh_next;
      k            <= k_next;
    end
  end

  always_ff @(posedge clk) begin
    phase   <= phase_next;
    op_r    <= op_r_next;
    off_r   <= off_r_next;
    rng_r   <= rng_r_next;
    acc     <= acc_next;
    prod    <= prod_next;
    prod_sh <= prod_sh_next;
    w       <= w_next;
    thresh  <= thresh_next;
    res     <= res_next;
    value   <= value_next;
  end

  // The remainder unit must be quiet whenever a new item can enter.
  a_idle_div_quiet: assert property (@(posedge clk) disable iff (rst)
    fsm == ST_IDLE |-> !div_busy)
    else $error("remainder unit busy while idle");

  // The increment stays odd, so the generator keeps its full period.
  a_inc_odd: assert property (@(posedge clk) disable iff (rst) inc[0])
    else $error("increment became even");

  // The Lemire threshold is always below the exclusive bound.
  a_thresh_below: assert property (@(posedge clk) disable iff (rst)
    (fsm == ST_LCHK && have_thresh) |-> thresh < excl)
    else $error("rejection threshold out of range");

  // An accepted item always leaves the idle state.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready) |=> fsm != ST_IDLE)
    else $error("item accepted without work starting");

endmodule
`default_nettype wire

### hdl/pcg_div.sv
// Bit-serial restoring divider returning the 64-bit remainder.
`default_nettype none
module pcg_div
  import pcg_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] dividend,
  input  wire logic [63:0] divisor,
  output logic             busy,
  output logic             done,
  output logic [63:0]      rem
);

  logic [63:0] dq;
  logic [63:0] dv;
  logic [6:0]  cnt;
  logic [64:0] trial;

  // One quotient bit per cycle.
  assign trial = {rem, dq[63]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        dq   <= dividend;
        dv   <= divisor;
        rem  <= '0;
      end else if (busy) begin
        dq <= {dq[62:0], 1'b0};
        if (trial >= {1'b0, dv}) begin
          rem <= 64'(trial - {1'b0, dv});
        end else begin
          rem <= trial[63:0];
        end
        cnt <= cnt + 7'd1;
        if (cnt == 7'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire
